FILE: hdl/ppmdec_pkg.sv
// ----------------------------------------------------------------------------
// ppmdec_pkg
// Shared types and constants for the PPM stream decoder.
// ----------------------------------------------------------------------------
package ppmdec_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_NUMBER  = 2'd1;
  localparam logic [1:0] ERR_EARLY   = 2'd2;
  localparam logic [1:0] ERR_MAXZERO = 2'd3;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // scaled sample ceiling
  localparam logic [7:0] SCALE_MAX = 8'd255;

  // event queue between parser and scaler
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // channel positions within a pixel
  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  // event from parser to scaler; kind pixel means one sample
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] wd;
    logic [15:0] ht;
    logic [15:0] mx;
    logic        bin;
    logic [15:0] val;
    logic [1:0]  chan;
    logic [1:0]  err;
    logic        last;
  } ev_t;

endpackage

FILE: hdl/ppmdec_front.sv
// ----------------------------------------------------------------------------
// ppmdec_front
// Byte parser: magic, header numbers, comments, sample extraction and
// pixel/row counting. Emits at most one event per accepted byte.
// ----------------------------------------------------------------------------
module ppmdec_front #(
  parameter int DIM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_marker,
  output logic              ev_valid,
  output ppmdec_pkg::ev_t   ev
);
  import ppmdec_pkg::*;

  localparam int ACC_W = (DIM_BITS > 16) ? DIM_BITS : 16;
  localparam logic [ACC_W+3:0] DIM_LIM = {{(ACC_W+4-DIM_BITS){1'b0}}, {DIM_BITS{1'b1}}};
  localparam logic [ACC_W+3:0] VAL_LIM = {{(ACC_W+4-16){1'b0}}, {16{1'b1}}};

  typedef enum logic [3:0] {
    PH_MAGIC, PH_MAGIC_P, PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H,
    PH_SKIP_M, PH_NUM_M, PH_SKIP_S, PH_NUM_S, PH_RAW, PH_DRAIN
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic                  in_comment_r, in_comment_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic [15:0]           max_r, max_nxt;
  logic                  bin_r, bin_nxt;
  logic [DIM_BITS-1:0]   col_r, col_nxt;
  logic [DIM_BITS-1:0]   row_r, row_nxt;
  logic [1:0]            chan_r, chan_nxt;
  logic [7:0]            high_r, high_nxt;
  logic                  half_r, half_nxt;

  logic                  is_digit, is_sep, is_hash, is_eol;
  logic [3:0]            dval;
  logic [ACC_W+3:0]      acc10;
  logic [DIM_BITS:0]     col_inc, row_inc;
  logic                  col_last, row_last;
  logic [31:0]           w32, h32;
  logic                  do_err, take;
  logic [1:0]            err_code;
  logic [15:0]           take_val;

  // byte classes
  assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign is_eol   = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_sep   = (data_byte == CH_SPACE) || is_eol;
  assign is_hash  = (data_byte == CH_HASH);
  assign dval     = 4'(data_byte - CH_0);
  assign acc10    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (ACC_W+4)'(dval);

  // position tracking
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_last = col_inc >= {1'b0, width_r};
  assign row_last = row_inc >= {1'b0, height_r};
  assign w32      = 32'(width_r);
  assign h32      = 32'(height_r);

  // parse step
  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    acc_nxt        = acc_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    max_nxt        = max_r;
    bin_nxt        = bin_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    chan_nxt       = chan_r;
    high_nxt       = high_r;
    half_nxt       = half_r;
    ev_valid       = 1'b0;
    ev             = '0;
    do_err         = 1'b0;
    err_code       = ERR_MAGIC;
    take           = 1'b0;
    take_val       = '0;

    if (accept) begin
      if (end_marker) begin
        in_comment_nxt = 1'b0;
        phase_nxt      = PH_MAGIC;
        if (phase_r == PH_MAGIC || phase_r == PH_DRAIN) begin
          ev_valid = 1'b0;
        end else if (phase_r == PH_NUM_S && chan_r == CHAN_BLUE && col_last && row_last) begin
          take     = 1'b1;
          take_val = acc_r[15:0];
        end else begin
          ev_valid = 1'b1;
          ev.kind  = KIND_ERROR;
          ev.err   = ERR_EARLY;
        end
      end else begin
        case (phase_r)
          PH_MAGIC: begin
            if (data_byte == CH_P) begin
              phase_nxt = PH_MAGIC_P;
            end else if (!is_sep) begin
              do_err   = 1'b1;
              err_code = ERR_MAGIC;
            end
          end
          PH_MAGIC_P: begin
            if (data_byte == CH_3 || data_byte == CH_6) begin
              bin_nxt        = (data_byte == CH_6);
              in_comment_nxt = 1'b0;
              col_nxt        = '0;
              row_nxt        = '0;
              chan_nxt       = CHAN_RED;
              half_nxt       = 1'b0;
              phase_nxt      = PH_SKIP_W;
            end else begin
              do_err   = 1'b1;
              err_code = ERR_MAGIC;
            end
          end
          PH_SKIP_W, PH_SKIP_H, PH_SKIP_M, PH_SKIP_S: begin
            if (in_comment_r) begin
              if (is_eol) in_comment_nxt = 1'b0;
            end else if (is_hash) begin
              in_comment_nxt = 1'b1;
            end else if (is_digit) begin
              acc_nxt = ACC_W'(dval);
              case (phase_r)
                PH_SKIP_W: phase_nxt = PH_NUM_W;
                PH_SKIP_H: phase_nxt = PH_NUM_H;
                PH_SKIP_M: phase_nxt = PH_NUM_M;
                default:   phase_nxt = PH_NUM_S;
              endcase
            end else if (!is_sep) begin
              do_err   = 1'b1;
              err_code = ERR_NUMBER;
            end
          end
          PH_NUM_W, PH_NUM_H, PH_NUM_M, PH_NUM_S: begin
            if (is_digit) begin
              if (acc10 > (((phase_r == PH_NUM_W) || (phase_r == PH_NUM_H)) ? DIM_LIM : VAL_LIM))
              begin
                do_err   = 1'b1;
                err_code = ERR_NUMBER;
              end else begin
                acc_nxt = acc10[ACC_W-1:0];
              end
            end else if (is_sep || is_hash) begin
              in_comment_nxt = is_hash;
              case (phase_r)
                PH_NUM_W: begin
                  width_nxt = acc_r[DIM_BITS-1:0];
                  phase_nxt = PH_SKIP_H;
                end
                PH_NUM_H: begin
                  height_nxt = acc_r[DIM_BITS-1:0];
                  phase_nxt  = PH_SKIP_M;
                end
                PH_NUM_M: begin
                  max_nxt = acc_r[15:0];
                  if (bin_r && is_hash) begin
                    do_err   = 1'b1;
                    err_code = ERR_NUMBER;
                  end else if (acc_r == '0) begin
                    do_err   = 1'b1;
                    err_code = ERR_MAXZERO;
                  end else begin
                    ev_valid = 1'b1;
                    ev.kind  = KIND_HEADER;
                    ev.wd    = w32[15:0];
                    ev.ht    = h32[15:0];
                    ev.mx    = acc_r[15:0];
                    ev.bin   = bin_r;
                    if (width_r == '0 || height_r == '0) begin
                      ev.last        = 1'b1;
                      phase_nxt      = PH_MAGIC;
                      in_comment_nxt = 1'b0;
                    end else begin
                      phase_nxt = bin_r ? PH_RAW : PH_SKIP_S;
                    end
                  end
                end
                default: begin
                  phase_nxt = PH_SKIP_S;
                  take      = 1'b1;
                  take_val  = acc_r[15:0];
                end
              endcase
            end else begin
              do_err   = 1'b1;
              err_code = ERR_NUMBER;
            end
          end
          PH_RAW: begin
            if (max_r > 16'd255) begin
              if (!half_r) begin
                high_nxt = data_byte;
                half_nxt = 1'b1;
              end else begin
                half_nxt = 1'b0;
                take     = 1'b1;
                take_val = {high_r, data_byte};
              end
            end else begin
              take     = 1'b1;
              take_val = {8'd0, data_byte};
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    // error ends the image
    if (do_err) begin
      ev_valid       = 1'b1;
      ev.kind        = KIND_ERROR;
      ev.err         = err_code;
      phase_nxt      = PH_DRAIN;
      in_comment_nxt = 1'b0;
    end

    // sample goes to the scaler; pixel bookkeeping here
    if (take) begin
      ev_valid = 1'b1;
      ev.kind  = KIND_PIXEL;
      ev.val   = take_val;
      ev.mx    = max_r;
      ev.chan  = chan_r;
      case (chan_r)
        CHAN_RED:   chan_nxt = CHAN_GREEN;
        CHAN_GREEN: chan_nxt = CHAN_BLUE;
        default: begin
          chan_nxt = CHAN_RED;
          if (col_last) begin
            col_nxt = '0;
            row_nxt = row_inc[DIM_BITS-1:0];
            if (row_last) begin
              ev.last        = 1'b1;
              phase_nxt      = PH_MAGIC;
              in_comment_nxt = 1'b0;
            end
          end else begin
            col_nxt = col_inc[DIM_BITS-1:0];
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      in_comment_r <= 1'b0;
      acc_r        <= '0;
      width_r      <= '0;
      height_r     <= '0;
      max_r        <= '0;
      bin_r        <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      chan_r       <= CHAN_RED;
      high_r       <= '0;
      half_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      acc_r        <= acc_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      max_r        <= max_nxt;
      bin_r        <= bin_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      chan_r       <= chan_nxt;
      high_r       <= high_nxt;
      half_r       <= half_nxt;
    end
  end

`ifndef SYNTH
  // samples are only produced once a nonzero maximum is known
  a_sample_has_max: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev.kind == KIND_PIXEL) |-> (max_r != 16'd0))
    else $error("sample event with zero maximum");
`endif

endmodule

FILE: hdl/ppmdec_fifo.sv
// ----------------------------------------------------------------------------
// ppmdec_fifo
// Short event queue between parser and scaler.
// ----------------------------------------------------------------------------
module ppmdec_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ppmdec_pkg::ev_t   wr_data,
  input  logic              rd_en,
  output ppmdec_pkg::ev_t   rd_data,
  output logic              full,
  output logic              empty
);
  import ppmdec_pkg::*;

  ev_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = wr_en ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd_en ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wptr_r] <= wr_data;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!full || rd_en))
    else $error("event queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("event queue underflow");
`endif

endmodule

FILE: hdl/ppmdec_back.sv
// ----------------------------------------------------------------------------
// ppmdec_back
// Scaler and result stage: scales samples to 8 bits with a multiply and an
// 8-step restoring divide, assembles pixels and holds the result register.
// ----------------------------------------------------------------------------
module ppmdec_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ppmdec_pkg::ev_t   q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_kind,
  output logic [15:0]       out_image_width,
  output logic [15:0]       out_image_height,
  output logic [15:0]       out_max_value,
  output logic              out_binary_format,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic [1:0]        out_error_code,
  output logic              out_last_pixel
);
  import ppmdec_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_PUT} bstate_t;

  bstate_t      state_r, state_nxt;
  ev_t          ev_r, ev_nxt;
  logic [24:0]  rem_r, rem_nxt;
  logic [16:0]  den_r, den_nxt;
  logic [7:0]   q_r, q_nxt;
  logic [2:0]   step_r, step_nxt;
  logic [7:0]   red_r, red_nxt;
  logic [7:0]   green_r, green_nxt;
  logic [7:0]   blue_r, blue_nxt;

  logic         valid_r, valid_nxt;
  logic [1:0]   kind_r, kind_nxt;
  logic [15:0]  wd_r, wd_nxt, ht_r, ht_nxt, mx_r, mx_nxt;
  logic         bin_r, bin_nxt;
  logic [7:0]   ored_r, ored_nxt, ogreen_r, ogreen_nxt, oblue_r, oblue_nxt;
  logic [1:0]   err_r, err_nxt;
  logic         last_r, last_nxt;

  logic [24:0]  trial;
  logic         fin;
  logic [7:0]   fin_q;

  assign trial = 25'(den_r) << step_r;

  // scaler sequencer and result register
  always_comb begin
    state_nxt  = state_r;
    ev_nxt     = ev_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    blue_nxt   = blue_r;
    valid_nxt  = valid_r;
    kind_nxt   = kind_r;
    wd_nxt     = wd_r;
    ht_nxt     = ht_r;
    mx_nxt     = mx_r;
    bin_nxt    = bin_r;
    ored_nxt   = ored_r;
    ogreen_nxt = ogreen_r;
    oblue_nxt  = oblue_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    fin        = 1'b0;
    fin_q      = '0;

    if (valid_r && pop) valid_nxt = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ev_nxt    = q_data;
          state_nxt = (q_data.kind == KIND_PIXEL) ? B_MUL : B_PUT;
        end
      end
      B_MUL: begin
        if (ev_r.val >= ev_r.mx) begin
          fin   = 1'b1;
          fin_q = SCALE_MAX;
        end else begin
          rem_nxt   = 25'(ev_r.val) * 25'd510 + 25'(ev_r.mx);
          den_nxt   = {ev_r.mx, 1'b0};
          q_nxt     = '0;
          step_nxt  = 3'd7;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        fin_q = q_r;
        if (rem_r >= trial) begin
          rem_nxt       = rem_r - trial;
          fin_q[step_r] = 1'b1;
        end
        q_nxt    = fin_q;
        step_nxt = step_r - 1'b1;
        if (step_r == 3'd0) fin = 1'b1;
      end
      B_PUT: begin
        if (!valid_r || pop) begin
          valid_nxt  = 1'b1;
          kind_nxt   = ev_r.kind;
          wd_nxt     = (ev_r.kind == KIND_HEADER) ? ev_r.wd : 16'd0;
          ht_nxt     = (ev_r.kind == KIND_HEADER) ? ev_r.ht : 16'd0;
          mx_nxt     = (ev_r.kind == KIND_HEADER) ? ev_r.mx : 16'd0;
          bin_nxt    = ev_r.bin;
          ored_nxt   = (ev_r.kind == KIND_PIXEL) ? red_r : 8'd0;
          ogreen_nxt = (ev_r.kind == KIND_PIXEL) ? green_r : 8'd0;
          oblue_nxt  = (ev_r.kind == KIND_PIXEL) ? blue_r : 8'd0;
          err_nxt    = ev_r.err;
          last_nxt   = ev_r.last;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    // sample scaled: hold it or complete the pixel
    if (fin) begin
      case (ev_r.chan)
        CHAN_RED: begin
          red_nxt   = fin_q;
          state_nxt = B_IDLE;
        end
        CHAN_GREEN: begin
          green_nxt = fin_q;
          state_nxt = B_IDLE;
        end
        default: begin
          blue_nxt  = fin_q;
          state_nxt = B_PUT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    ev_r     <= ev_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    q_r      <= q_nxt;
    step_r   <= step_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    kind_r   <= kind_nxt;
    wd_r     <= wd_nxt;
    ht_r     <= ht_nxt;
    mx_r     <= mx_nxt;
    bin_r    <= bin_nxt;
    ored_r   <= ored_nxt;
    ogreen_r <= ogreen_nxt;
    oblue_r  <= oblue_nxt;
    err_r    <= err_nxt;
    last_r   <= last_nxt;
  end

  // result ports
  assign empty             = !valid_r;
  assign out_kind          = kind_r;
  assign out_image_width   = wd_r;
  assign out_image_height  = ht_r;
  assign out_max_value     = mx_r;
  assign out_binary_format = bin_r;
  assign out_red_out       = ored_r;
  assign out_green_out     = ogreen_r;
  assign out_blue_out      = oblue_r;
  assign out_error_code    = err_r;
  assign out_last_pixel    = last_r;

`ifndef SYNTH
  a_load_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(state_r == B_PUT))
    else $error("result loaded outside the put state");
`endif

endmodule

FILE: hdl/ppm_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// ppm_stream_decoder_top
// PPM P3/P6 byte-stream decoder: parser front end, event queue, scaler back
// end with a registered result.
// ----------------------------------------------------------------------------
// a header or error result passes from the event queue via the scaler's event
//   register to the result register, a pixel once its last sample is scaled
// throughput: one byte per cycle while the 4-entry event queue has room; the
//   scaler finishes a sample before it takes another from the queue
// reset: synchronous active-low rst_n clears parser phase, queue and result valid
module ppm_stream_decoder_top #(
  parameter int DIM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_marker,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [15:0] out_max_value,
  output logic        out_binary_format,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [1:0]  out_error_code,
  output logic        out_last_pixel
);
  import ppmdec_pkg::*;

  logic accept;
  logic ev_valid;
  ev_t  ev;
  ev_t  q_data;
  logic q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  // parser
  ppmdec_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .end_marker (in_end_marker),
    .ev_valid   (ev_valid),
    .ev         (ev)
  );

  // event queue
  ppmdec_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_valid),
    .wr_data (ev),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // scaler and result stage
  ppmdec_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (q_data),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_image_width   (out_image_width),
    .out_image_height  (out_image_height),
    .out_max_value     (out_max_value),
    .out_binary_format (out_binary_format),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_error_code    (out_error_code),
    .out_last_pixel    (out_last_pixel)
  );

`ifndef SYNTH
  a_event_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid |-> (accept && !q_full))
    else $error("parser event without an accepted transaction");
`endif

endmodule
